@@ hw/rtl/gmdc_pkg.sv @@
`default_nettype none

package gmdc_pkg;

   localparam int ACC_W = 23;

   // Day number of 2012-12-21 counted from day 0 of year 0.
   localparam logic [ACC_W-1:0] EPOCH_DAYS   = 23'd735223;
   localparam logic [ACC_W-1:0] CYCLE_DAYS   = 23'd1872000;
   localparam logic [ACC_W-1:0] QUAD_DAYS    = 23'd146097;
   localparam logic [ACC_W-1:0] CENT_DAYS    = 23'd36524;
   localparam logic [ACC_W-1:0] FOUR_DAYS    = 23'd1460;
   localparam logic [ACC_W-1:0] YEAR_DAYS    = 23'd365;
   localparam logic [12:0]      RECIP_100    = 13'd5243;

   typedef enum logic [1:0] {
      DIG_BAKTUN = 2'd0,
      DIG_KATUN  = 2'd1,
      DIG_TUN    = 2'd2,
      DIG_WINAL  = 2'd3
   } dig_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_G_QUO,
      OP_G_LEAP,
      OP_G_MUL,
      OP_G_ADD,
      OP_G_WRAP,
      OP_G_DIG,
      OP_M_SUM,
      OP_M_QUAD,
      OP_M_CENT,
      OP_M_FOUR,
      OP_M_YEAR,
      OP_M_MON,
      OP_M_FIX,
      OP_OUT
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_G_QUO,
      ST_G_LEAP,
      ST_G_MUL,
      ST_G_ADD,
      ST_G_WRAP,
      ST_G_DIG,
      ST_M_SUM,
      ST_M_QUAD,
      ST_M_CENT,
      ST_M_FOUR,
      ST_M_YEAR,
      ST_M_MON,
      ST_M_FIX,
      ST_DONE
   } state_type;

   typedef struct packed {
      op_type  op;
      dig_type dig;
   } cmd_type;

   typedef struct packed {
      logic ge;
      logic neg;
   } sts_type;

   // Days before the first of month index i (0 is January), common year.
   function automatic logic [8:0] cum_days(input logic [3:0] i);
      logic [8:0] r;
      unique case (i)
         4'd0:    r = 9'd0;
         4'd1:    r = 9'd31;
         4'd2:    r = 9'd59;
         4'd3:    r = 9'd90;
         4'd4:    r = 9'd120;
         4'd5:    r = 9'd151;
         4'd6:    r = 9'd181;
         4'd7:    r = 9'd212;
         4'd8:    r = 9'd243;
         4'd9:    r = 9'd273;
         4'd10:   r = 9'd304;
         4'd11:   r = 9'd334;
         4'd12:   r = 9'd365;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   function automatic logic [ACC_W-1:0] dig_weight(input dig_type d);
      logic [ACC_W-1:0] r;
      unique case (d)
         DIG_BAKTUN: r = 23'd144000;
         DIG_KATUN:  r = 23'd7200;
         DIG_TUN:    r = 23'd360;
         DIG_WINAL:  r = 23'd20;
         default:    r = 23'd20;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/gmdc_ctrl.sv @@
`default_nettype none

module gmdc_ctrl
   import gmdc_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     req_valid,
   output logic    req_ready,
   input  wire     req_mode,
   output logic    rsp_valid,
   input  wire     rsp_ready,
   output cmd_type cmd,
   input  sts_type sts
);

   state_type state_ff, state_in;
   dig_type   dig_ff, dig_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dig_ff       <= DIG_BAKTUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dig_ff       <= dig_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      dig_in       = dig_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd.op       = OP_NOP;
      cmd.dig      = dig_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               dig_in   = DIG_BAKTUN;
               state_in = req_mode ? ST_M_SUM : ST_G_QUO;
            end
         end
         ST_G_QUO: begin
            cmd.op   = OP_G_QUO;
            state_in = ST_G_LEAP;
         end
         ST_G_LEAP: begin
            cmd.op   = OP_G_LEAP;
            state_in = ST_G_MUL;
         end
         ST_G_MUL: begin
            cmd.op   = OP_G_MUL;
            state_in = ST_G_ADD;
         end
         ST_G_ADD: begin
            cmd.op   = OP_G_ADD;
            state_in = sts.neg ? ST_DONE : ST_G_WRAP;
         end
         ST_G_WRAP: begin
            cmd.op = OP_G_WRAP;
            if (!sts.ge) state_in = ST_G_DIG;
         end
         ST_G_DIG: begin
            cmd.op = OP_G_DIG;
            if (!sts.ge) begin
               if (dig_ff == DIG_WINAL) state_in = ST_DONE;
               else dig_in = dig_type'(dig_ff + 2'd1);
            end
         end
         ST_M_SUM: begin
            cmd.op   = OP_M_SUM;
            state_in = ST_M_QUAD;
         end
         ST_M_QUAD: begin
            cmd.op = OP_M_QUAD;
            if (!sts.ge) state_in = ST_M_CENT;
         end
         ST_M_CENT: begin
            cmd.op = OP_M_CENT;
            if (!sts.ge) state_in = ST_M_FOUR;
         end
         ST_M_FOUR: begin
            cmd.op = OP_M_FOUR;
            if (!sts.ge) state_in = ST_M_YEAR;
         end
         ST_M_YEAR: begin
            cmd.op = OP_M_YEAR;
            if (!sts.ge) state_in = ST_M_MON;
         end
         ST_M_MON: begin
            cmd.op = OP_M_MON;
            if (!sts.ge) state_in = ST_M_FIX;
         end
         ST_M_FIX: begin
            cmd.op   = OP_M_FIX;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // The result register is reloaded once the previous result is gone.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ hw/rtl/gmdc_dpath.sv @@
`default_nettype none

module gmdc_dpath
   import gmdc_pkg::*;
(
   input  wire         clock,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  wire         req_mode,
   input  wire  [13:0] req_year_in,
   input  wire  [3:0]  req_month_in,
   input  wire  [4:0]  req_day_in,
   input  wire  [3:0]  req_baktun_in,
   input  wire  [4:0]  req_katun_in,
   input  wire  [4:0]  req_tun_in,
   input  wire  [4:0]  req_winal_in,
   input  wire  [4:0]  req_kin_in,
   output logic [13:0] rsp_year_out,
   output logic [3:0]  rsp_month_out,
   output logic [4:0]  rsp_day_out,
   output logic [3:0]  rsp_baktun_out,
   output logic [4:0]  rsp_katun_out,
   output logic [4:0]  rsp_tun_out,
   output logic [4:0]  rsp_winal_out,
   output logic [4:0]  rsp_kin_out,
   output logic        rsp_range_error
);

   logic             mode_ff;
   logic [13:0]      year_ff;
   logic [3:0]       month_ff;
   logic [4:0]       day_ff, katun_ff, tun_ff, winal_ff, kin_ff;
   logic [3:0]       baktun_ff;
   logic [ACC_W-1:0] acc_ff;
   logic [7:0]       qx_ff, qy_ff;
   logic [11:0]      lc_ff;
   logic             leap_ff, err_ff, cyc0_ff, first_ff, lp_ff;
   logic [3:0]       dbak_ff;
   logic [4:0]       dkat_ff, dtun_ff, dwin_ff;
   logic [13:0]      yo_ff;
   logic [3:0]       mo_ff;

   logic [13:0]      ym1;
   logic [26:0]      px, py;
   logic [13:0]      rem100;
   logic [3:0]       mcl;
   logic [ACC_W-1:0] gsum, msum, sub, fix;
   logic             ge_raw;

   assign ym1 = year_ff - 14'd1;
   assign px  = {13'd0, ym1} * {14'd0, RECIP_100};
   assign py  = {13'd0, year_ff} * {14'd0, RECIP_100};
   assign rem100 = year_ff - ({6'd0, qy_ff} * 14'd100);

   always_comb begin
      if (month_ff == 4'd0) mcl = 4'd1;
      else if (month_ff > 4'd12) mcl = 4'd12;
      else mcl = month_ff;
   end

   assign gsum = acc_ff + {14'd0, cum_days(mcl - 4'd1)}
               + {22'd0, leap_ff && (mcl > 4'd2)} + {18'd0, day_ff};

   assign msum = {18'd0, kin_ff} + ({18'd0, winal_ff} * 23'd20)
               + ({18'd0, tun_ff} * 23'd360) + ({18'd0, katun_ff} * 23'd7200)
               + ({19'd0, baktun_ff} * 23'd144000) + EPOCH_DAYS;

   assign fix = {14'd0, cum_days(mo_ff)} + {22'd0, lp_ff && (mo_ff > 4'd1)};

   always_comb begin
      case (cmd.op)
         OP_G_WRAP: sub = CYCLE_DAYS;
         OP_G_DIG:  sub = dig_weight(cmd.dig);
         OP_M_QUAD: sub = QUAD_DAYS;
         OP_M_CENT: sub = CENT_DAYS + {22'd0, cyc0_ff};
         OP_M_FOUR: sub = FOUR_DAYS + {22'd0, first_ff ? cyc0_ff : 1'b1};
         OP_M_YEAR: sub = YEAR_DAYS + {22'd0, lp_ff};
         OP_M_MON:  sub = {14'd0, cum_days(mo_ff + 4'd1)}
                        + {22'd0, lp_ff && (mo_ff >= 4'd1)};
         default:   sub = '0;
      endcase
   end

   assign ge_raw = acc_ff >= sub;
   assign sts    = '{ge:  ge_raw && ((cmd.op != OP_M_MON) || (mo_ff < 4'd11)),
                     neg: gsum < EPOCH_DAYS};

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            mode_ff   <= req_mode;
            year_ff   <= req_year_in;
            month_ff  <= req_month_in;
            day_ff    <= req_day_in;
            baktun_ff <= req_baktun_in;
            katun_ff  <= req_katun_in;
            tun_ff    <= req_tun_in;
            winal_ff  <= req_winal_in;
            kin_ff    <= req_kin_in;
            dbak_ff   <= '0;
            dkat_ff   <= '0;
            dtun_ff   <= '0;
            dwin_ff   <= '0;
            err_ff    <= 1'b0;
         end
         OP_G_QUO: begin
            qx_ff <= px[26:19];
            qy_ff <= py[26:19];
         end
         OP_G_LEAP: begin
            // Leap years before this one: x/4 - x/100 + x/400 with x = year - 1.
            if (year_ff == 14'd0) lc_ff <= '0;
            else lc_ff <= ym1[13:2] - {4'd0, qx_ff} + {6'd0, qx_ff[7:2]};
            leap_ff <= (year_ff[1:0] == 2'd0)
                    && ((rem100 != 14'd0) || (qy_ff[1:0] == 2'd0));
         end
         OP_G_MUL: acc_ff <= ({9'd0, year_ff} * 23'd365) + {11'd0, lc_ff};
         OP_G_ADD: begin
            acc_ff <= gsum - EPOCH_DAYS;
            err_ff <= sts.neg;
         end
         OP_G_WRAP: if (sts.ge) acc_ff <= acc_ff - sub;
         OP_G_DIG: begin
            if (sts.ge) begin
               acc_ff <= acc_ff - sub;
               case (cmd.dig)
                  DIG_BAKTUN: dbak_ff <= dbak_ff + 4'd1;
                  DIG_KATUN:  dkat_ff <= dkat_ff + 5'd1;
                  DIG_TUN:    dtun_ff <= dtun_ff + 5'd1;
                  default:    dwin_ff <= dwin_ff + 5'd1;
               endcase
            end
         end
         OP_M_SUM: begin
            acc_ff   <= msum;
            yo_ff    <= '0;
            mo_ff    <= '0;
            cyc0_ff  <= 1'b1;
            first_ff <= 1'b1;
         end
         OP_M_QUAD: begin
            if (sts.ge) begin
               acc_ff <= acc_ff - sub;
               yo_ff  <= yo_ff + 14'd400;
            end
         end
         OP_M_CENT: begin
            if (sts.ge) begin
               acc_ff  <= acc_ff - sub;
               yo_ff   <= yo_ff + 14'd100;
               cyc0_ff <= 1'b0;
            end
         end
         OP_M_FOUR: begin
            if (sts.ge) begin
               acc_ff   <= acc_ff - sub;
               yo_ff    <= yo_ff + 14'd4;
               first_ff <= 1'b0;
            end else begin
               // A century year is leap only at the start of a 400-year cycle.
               lp_ff <= first_ff ? cyc0_ff : 1'b1;
            end
         end
         OP_M_YEAR: begin
            if (sts.ge) begin
               acc_ff <= acc_ff - sub;
               yo_ff  <= yo_ff + 14'd1;
               lp_ff  <= 1'b0;
            end
         end
         OP_M_MON: if (sts.ge) mo_ff <= mo_ff + 4'd1;
         OP_M_FIX: acc_ff <= acc_ff - fix;
         OP_OUT: begin
            if (mode_ff) begin
               rsp_year_out    <= yo_ff;
               rsp_month_out   <= mo_ff + 4'd1;
               rsp_day_out     <= acc_ff[4:0] + 5'd1;
               rsp_baktun_out  <= '0;
               rsp_katun_out   <= '0;
               rsp_tun_out     <= '0;
               rsp_winal_out   <= '0;
               rsp_kin_out     <= '0;
               rsp_range_error <= 1'b0;
            end else begin
               rsp_year_out    <= '0;
               rsp_month_out   <= '0;
               rsp_day_out     <= '0;
               rsp_baktun_out  <= err_ff ? 4'd0 : dbak_ff;
               rsp_katun_out   <= err_ff ? 5'd0 : dkat_ff;
               rsp_tun_out     <= err_ff ? 5'd0 : dtun_ff;
               rsp_winal_out   <= err_ff ? 5'd0 : dwin_ff;
               rsp_kin_out     <= err_ff ? 5'd0 : acc_ff[4:0];
               rsp_range_error <= err_ff;
            end
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

@@ hw/rtl/gregorian_maya_date_converter_top.sv @@
`default_nettype none
// Gregorian / Maya long count date converter.
// One date enters on the req_ channel (valid/ready) and one result leaves on
// the rsp_ channel. req_mode 0 turns a Gregorian date into long count digits,
// flagging dates before 2012-12-21 with rsp_range_error; req_mode 1 turns a
// long count into a Gregorian date. Unused result fields are zero.
// The block works on one date at a time; req_ready is high only while it is
// idle. A Gregorian date passes the quotient, leap, multiply and add states
// and, unless it precedes the epoch, the wrap and digit loops; a long count
// passes a sum state, the year block and month loops and a fix state. The
// compare-and-subtract loops remove one cycle, one digit weight, one year block
// or one month per cycle. The next date can be taken in the cycle after the
// result is loaded. A finished result sits in an output register, so the next
// date can be taken while the receiver stalls; the loop then waits in its final
// state until that register is free. Synchronous reset returns the
// controller to idle and drops rsp_valid; no clearing pass is needed.
module gregorian_maya_date_converter_top
   import gmdc_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire         req_mode,
   input  wire  [13:0] req_year_in,
   input  wire  [3:0]  req_month_in,
   input  wire  [4:0]  req_day_in,
   input  wire  [3:0]  req_baktun_in,
   input  wire  [4:0]  req_katun_in,
   input  wire  [4:0]  req_tun_in,
   input  wire  [4:0]  req_winal_in,
   input  wire  [4:0]  req_kin_in,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [13:0] rsp_year_out,
   output logic [3:0]  rsp_month_out,
   output logic [4:0]  rsp_day_out,
   output logic [3:0]  rsp_baktun_out,
   output logic [4:0]  rsp_katun_out,
   output logic [4:0]  rsp_tun_out,
   output logic [4:0]  rsp_winal_out,
   output logic [4:0]  rsp_kin_out,
   output logic        rsp_range_error
);

   cmd_type cmd;
   sts_type sts;

   gmdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   gmdc_dpath u_dpath (
      .clock           (clock),
      .cmd             (cmd),
      .sts             (sts),
      .req_mode        (req_mode),
      .req_year_in     (req_year_in),
      .req_month_in    (req_month_in),
      .req_day_in      (req_day_in),
      .req_baktun_in   (req_baktun_in),
      .req_katun_in    (req_katun_in),
      .req_tun_in      (req_tun_in),
      .req_winal_in    (req_winal_in),
      .req_kin_in      (req_kin_in),
      .rsp_year_out    (rsp_year_out),
      .rsp_month_out   (rsp_month_out),
      .rsp_day_out     (rsp_day_out),
      .rsp_baktun_out  (rsp_baktun_out),
      .rsp_katun_out   (rsp_katun_out),
      .rsp_tun_out     (rsp_tun_out),
      .rsp_winal_out   (rsp_winal_out),
      .rsp_kin_out     (rsp_kin_out),
      .rsp_range_error (rsp_range_error)
   );

   // After a transfer in, the block is busy in the cycle after it.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while a conversion was running");

   // A range error carries zero digits.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_error |->
         rsp_baktun_out == 4'd0 && rsp_katun_out == 5'd0 && rsp_kin_out == 5'd0)
      else $error("range error with nonzero digits");

   // The remainder loops leave every digit below its radix.
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kin_out < 5'd20 && rsp_winal_out < 5'd18
         && rsp_tun_out < 5'd20 && rsp_katun_out < 5'd20 && rsp_month_out <= 4'd12)
      else $error("result digit out of range");

endmodule

`default_nettype wire
